// ----- sv/bclp_pkg.sv -----
// ---------------------------------------------------------------------------
// bclp_pkg: shared types and constants for the coordinate list parser
// character codes, result kinds, error codes, phase encoding, result record
// ---------------------------------------------------------------------------
package bclp_pkg;

   // sizing
   localparam int CharWidth   = 8;
   localparam int KindWidth   = 2;
   localparam int IndexWidth  = 3;
   localparam int ValueWidth  = 63;
   localparam int CountWidth  = 4;
   localparam int ErrorWidth  = 3;
   localparam int AddrWidth   = 3;
   localparam int DataWidth   = 32;

   // most coordinates the list can hold
   localparam logic [CountWidth-1:0] MaxDims = 4'd8;
   localparam logic [CountWidth-1:0] MaxCoordsReset = 4'd8;

   // register index of max_coords
   localparam logic RegMaxCoords = 1'b0;

   // characters
   localparam logic [CharWidth-1:0] CharNul   = 8'h00;
   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharNine  = 8'h39;
   localparam logic [CharWidth-1:0] CharComma = 8'h2C;
   localparam logic [CharWidth-1:0] CharOpen  = 8'h5B;
   localparam logic [CharWidth-1:0] CharClose = 8'h5D;

   // result kinds
   localparam logic [KindWidth-1:0] KindCoord = 2'd0;
   localparam logic [KindWidth-1:0] KindDone  = 2'd1;
   localparam logic [KindWidth-1:0] KindError = 2'd2;

   // error codes
   localparam logic [ErrorWidth-1:0] ErrNone      = 3'd0;
   localparam logic [ErrorWidth-1:0] ErrNoBracket = 3'd1;
   localparam logic [ErrorWidth-1:0] ErrEmpty     = 3'd2;
   localparam logic [ErrorWidth-1:0] ErrTooMany   = 3'd3;
   localparam logic [ErrorWidth-1:0] ErrBadChar   = 3'd4;
   localparam logic [ErrorWidth-1:0] ErrTrailing  = 3'd5;
   localparam logic [ErrorWidth-1:0] ErrEarlyEnd  = 3'd6;
   localparam logic [ErrorWidth-1:0] ErrOverflow  = 3'd7;

   // parser phase
   typedef enum logic [3:0] {
      PH_OPEN    = 4'b0001,
      PH_LIST    = 4'b0010,
      PH_CLOSED  = 4'b0100,
      PH_SWALLOW = 4'b1000
   } phase_type;

   // one result transaction
   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [IndexWidth-1:0] index;
      logic [ValueWidth-1:0] value;
      logic [CountWidth-1:0] count;
      logic [ErrorWidth-1:0] error;
      logic                  last;
   } result_type;

endpackage

// ----- sv/bracket_coord_list_parser_core.sv -----
// ---------------------------------------------------------------------------
// bracket_coord_list_parser_core: streaming parser for "[d,d,...]" strings
// one character per transaction in, coordinate / completion / error out
// ---------------------------------------------------------------------------
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------
// req      | in        | req_valid/req_ready  | req_char_in
// rsp      | out       | rsp_valid/rsp_ready  | kind, index, value, count,
//          |           |                      | error_code, last
// csr      | in        | psel/penable/pwrite  | paddr, pwdata -> max_coords
//
// one character per clock while the result register is not stalled; a character
// waits in the input register and its result, if any, lands in the result register
// longest path is the 67-bit multiply-by-ten-plus-digit add and overflow test
// a stalled result register holds the input register, even for a character
// that makes no result, and req_ready drops only while both are full
// synchronous active-high reset: parser rearmed, max_coords back to 8
//
module bracket_coord_list_parser_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // character input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bclp_pkg::CharWidth-1:0]        req_char_in,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bclp_pkg::KindWidth-1:0]        rsp_result_kind,
   output logic [bclp_pkg::IndexWidth-1:0]       rsp_coord_index,
   output logic [bclp_pkg::ValueWidth-1:0]       rsp_coord_value,
   output logic [bclp_pkg::CountWidth-1:0]       rsp_coord_count,
   output logic [bclp_pkg::ErrorWidth-1:0]       rsp_error_code,
   output logic                                  rsp_last,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [bclp_pkg::AddrWidth-1:0]        paddr,
   input  logic [bclp_pkg::DataWidth-1:0]        pwdata,
   output logic [bclp_pkg::DataWidth-1:0]        prdata,
   output logic                                  pready
);

   // widened accumulator for the multiply-add
   localparam int WideWidth = bclp_pkg::ValueWidth + 4;

   // ---------------- configuration register ----------------
   logic [bclp_pkg::CountWidth-1:0] max_coords_ff, max_coords_in;
   logic                            csr_write;
   logic                            csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == bclp_pkg::RegMaxCoords);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      max_coords_in = max_coords_ff;
      if (csr_write && csr_hit) begin
         max_coords_in = pwdata[bclp_pkg::CountWidth-1:0];
      end
   end

   // read back: only the one register decodes, the rest read zero
   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = {{(bclp_pkg::DataWidth - bclp_pkg::CountWidth){1'b0}}, max_coords_ff};
      end
   end

   // ---------------- input register ----------------
   logic                           s1_valid_ff, s1_valid_in;
   logic [bclp_pkg::CharWidth-1:0] s1_char_ff, s1_char_in;
   logic                           s1_advance;
   logic                           req_accept;

   // result register, declared here for the advance term
   logic                 rsp_valid_ff, rsp_valid_in;
   bclp_pkg::result_type rsp_data_ff, rsp_data_in;

   // the parser stage moves whenever the result register can take a result
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_char_in  = req_char_in;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- parser state ----------------
   bclp_pkg::phase_type              phase_ff, phase_in;
   logic [bclp_pkg::ValueWidth-1:0]  acc_ff, acc_in;
   logic                             digit_seen_ff, digit_seen_in;
   logic [bclp_pkg::CountWidth-1:0]  coords_done_ff, coords_done_in;

   logic [bclp_pkg::CharWidth-1:0]   char_cur;
   logic [3:0]                       digit_full;
   logic [WideWidth-1:0]             acc_wide;
   logic [WideWidth-1:0]             acc_scaled;
   logic                             acc_overflow;
   logic [bclp_pkg::CountWidth-1:0]  limit;
   logic                             emit;
   bclp_pkg::result_type             result;

   assign char_cur   = s1_char_ff;
   // '0'..'9' sit at 0x30..0x39, so the low nibble is the digit value
   assign digit_full = char_cur[3:0];
   assign acc_wide   = {4'b0, acc_ff};

   // acc * 10 + digit as two shifted copies plus the digit
   assign acc_scaled = (acc_wide << 3) + (acc_wide << 1)
                     + {{(WideWidth - 4){1'b0}}, digit_full};

   // any bit at or above 2^63 means the value no longer fits
   assign acc_overflow = (acc_scaled[WideWidth-1:bclp_pkg::ValueWidth] != '0);

   // limit in use is min(max_coords, MaxDims)
   assign limit = (max_coords_ff < bclp_pkg::MaxDims) ? max_coords_ff : bclp_pkg::MaxDims;

   always_comb begin
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      digit_seen_in  = digit_seen_ff;
      coords_done_in = coords_done_ff;
      emit           = 1'b0;
      result         = '0;

      if (char_cur == bclp_pkg::CharNul) begin
         // end of string: rearm, report according to where we were
         phase_in       = bclp_pkg::PH_OPEN;
         acc_in         = '0;
         digit_seen_in  = 1'b0;
         coords_done_in = '0;
         case (phase_ff)
            bclp_pkg::PH_OPEN: begin
               emit         = 1'b1;
               result.kind  = bclp_pkg::KindError;
               result.error = bclp_pkg::ErrNoBracket;
               result.last  = 1'b1;
            end
            bclp_pkg::PH_LIST: begin
               emit         = 1'b1;
               result.kind  = bclp_pkg::KindError;
               result.error = bclp_pkg::ErrEarlyEnd;
               result.last  = 1'b1;
            end
            bclp_pkg::PH_CLOSED: begin
               emit         = 1'b1;
               result.kind  = bclp_pkg::KindDone;
               result.count = coords_done_ff;
               result.last  = 1'b1;
            end
            default: begin
               // swallowing: rearm silently
               emit = 1'b0;
            end
         endcase
      end else begin
         case (phase_ff)
            bclp_pkg::PH_OPEN: begin
               if (char_cur == bclp_pkg::CharOpen) begin
                  phase_in = bclp_pkg::PH_LIST;
               end else begin
                  phase_in     = bclp_pkg::PH_SWALLOW;
                  emit         = 1'b1;
                  result.kind  = bclp_pkg::KindError;
                  result.error = bclp_pkg::ErrNoBracket;
                  result.last  = 1'b1;
               end
            end
            bclp_pkg::PH_LIST: begin
               if (char_cur inside {[bclp_pkg::CharZero:bclp_pkg::CharNine]}) begin
                  if (acc_overflow) begin
                     phase_in     = bclp_pkg::PH_SWALLOW;
                     emit         = 1'b1;
                     result.kind  = bclp_pkg::KindError;
                     result.error = bclp_pkg::ErrOverflow;
                     result.last  = 1'b1;
                  end else begin
                     acc_in        = acc_scaled[bclp_pkg::ValueWidth-1:0];
                     digit_seen_in = 1'b1;
                  end
               end else if (char_cur inside {bclp_pkg::CharComma, bclp_pkg::CharClose}) begin
                  // empty field is checked before the limit
                  if (!digit_seen_ff) begin
                     phase_in     = bclp_pkg::PH_SWALLOW;
                     emit         = 1'b1;
                     result.kind  = bclp_pkg::KindError;
                     result.error = bclp_pkg::ErrEmpty;
                     result.last  = 1'b1;
                  end else if (coords_done_ff >= limit) begin
                     phase_in     = bclp_pkg::PH_SWALLOW;
                     emit         = 1'b1;
                     result.kind  = bclp_pkg::KindError;
                     result.error = bclp_pkg::ErrTooMany;
                     result.last  = 1'b1;
                  end else begin
                     emit           = 1'b1;
                     result.kind    = bclp_pkg::KindCoord;
                     result.index   = coords_done_ff[bclp_pkg::IndexWidth-1:0];
                     result.value   = acc_ff;
                     coords_done_in = coords_done_ff + 4'd1;
                     acc_in         = '0;
                     digit_seen_in  = 1'b0;
                     if (char_cur == bclp_pkg::CharClose) begin
                        phase_in = bclp_pkg::PH_CLOSED;
                     end
                  end
               end else begin
                  phase_in     = bclp_pkg::PH_SWALLOW;
                  emit         = 1'b1;
                  result.kind  = bclp_pkg::KindError;
                  result.error = bclp_pkg::ErrBadChar;
                  result.last  = 1'b1;
               end
            end
            bclp_pkg::PH_CLOSED: begin
               phase_in     = bclp_pkg::PH_SWALLOW;
               emit         = 1'b1;
               result.kind  = bclp_pkg::KindError;
               result.error = bclp_pkg::ErrTrailing;
               result.last  = 1'b1;
            end
            default: begin
               // swallowing until the next nul
               emit = 1'b0;
            end
         endcase
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_data_in = result;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_data_ff.kind;
   assign rsp_coord_index = rsp_data_ff.index;
   assign rsp_coord_value = rsp_data_ff.value;
   assign rsp_coord_count = rsp_data_ff.count;
   assign rsp_error_code  = rsp_data_ff.error;
   assign rsp_last        = rsp_data_ff.last;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         max_coords_ff  <= bclp_pkg::MaxCoordsReset;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= bclp_pkg::PH_OPEN;
         acc_ff         <= '0;
         digit_seen_ff  <= 1'b0;
         coords_done_ff <= '0;
      end else begin
         max_coords_ff <= max_coords_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (s1_advance) begin
            phase_ff       <= phase_in;
            acc_ff         <= acc_in;
            digit_seen_ff  <= digit_seen_in;
            coords_done_ff <= coords_done_in;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_char_ff  <= s1_char_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- assertions ----------------

   // the coordinate count never passes the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      coords_done_ff <= bclp_pkg::MaxDims)
      else $error("coordinate count beyond list size");

   // no digit seen means the accumulator is still clear
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      !digit_seen_ff |-> (acc_ff == '0))
      else $error("accumulator holds value without a digit");

   // a nul always rearms the parser
   a_nul_rearm: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && (char_cur == bclp_pkg::CharNul))
      |=> (phase_ff == bclp_pkg::PH_OPEN) && (coords_done_ff == '0) && !digit_seen_ff)
      else $error("nul did not rearm the parser");

   // coordinate results never end a string and carry no error code
   a_coord_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.kind == bclp_pkg::KindCoord))
      |-> (!rsp_data_ff.last && (rsp_data_ff.error == bclp_pkg::ErrNone)))
      else $error("coordinate result marked last or with error");

endmodule
